// File: sv/qsvge_pkg.sv
// Shared types and constants for the qubit state vector gate engine.
// No dependencies; compile first.
package qsvge_pkg;

   localparam int OPCODE_W  = 3;
   localparam int QUBIT_W   = 4;
   localparam int INDEX_W   = 10;
   localparam int PART_W    = 16;
   localparam int AMP_W     = 2 * PART_W;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 4;
   localparam int NUM_REGS  = 8;

   localparam logic signed [PART_W-1:0] ONE_Q15  = 16'sd32767;
   localparam logic signed [PART_W-1:0] MAX_Q15  = 16'sd32767;
   localparam logic signed [PART_W-1:0] MIN_Q15  = -16'sd32768;

   localparam logic [OPCODE_W-1:0] OP_RESET = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_GATE  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_CNOT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_QUBIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAME_QUBIT = 2'd2;

   localparam logic [2:0] REG_M00_RE = 3'd0;
   localparam logic [2:0] REG_M00_IM = 3'd1;
   localparam logic [2:0] REG_M01_RE = 3'd2;
   localparam logic [2:0] REG_M01_IM = 3'd3;
   localparam logic [2:0] REG_M10_RE = 3'd4;
   localparam logic [2:0] REG_M10_IM = 3'd5;
   localparam logic [2:0] REG_M11_RE = 3'd6;
   localparam logic [2:0] REG_M11_IM = 3'd7;

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b000_0000_0001,
      ST_IDLE  = 11'b000_0000_0010,
      ST_RD    = 11'b000_0000_0100,
      ST_RDW   = 11'b000_0000_1000,
      ST_RDA   = 11'b000_0001_0000,
      ST_RDB   = 11'b000_0010_0000,
      ST_CAPB  = 11'b000_0100_0000,
      ST_MAC   = 11'b000_1000_0000,
      ST_WRA   = 11'b001_0000_0000,
      ST_WRB   = 11'b010_0000_0000,
      ST_DONE  = 11'b100_0000_0000
   } state_type;

endpackage

// File: sv/qsvge_if.sv
// Request and response channel interfaces for the gate engine.
// Depends on qsvge_pkg for field widths.
interface qsvge_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [qsvge_pkg::OPCODE_W-1:0]       opcode;
   logic [qsvge_pkg::QUBIT_W-1:0]        target_qubit;
   logic [qsvge_pkg::QUBIT_W-1:0]        control_qubit;
   logic [qsvge_pkg::INDEX_W-1:0]        amp_index;
   logic signed [qsvge_pkg::PART_W-1:0]  load_real;
   logic signed [qsvge_pkg::PART_W-1:0]  load_imag;

   modport source (output valid, opcode, target_qubit, control_qubit, amp_index,
                   load_real, load_imag, input ready);
   modport sink   (input valid, opcode, target_qubit, control_qubit, amp_index,
                   load_real, load_imag, output ready);
endinterface

interface qsvge_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qsvge_pkg::PART_W-1:0]  read_real;
   logic signed [qsvge_pkg::PART_W-1:0]  read_imag;
   logic [qsvge_pkg::STATUS_W-1:0]       status;
   logic                                 saturated;

   modport source (output valid, read_real, read_imag, status, saturated, input ready);
   modport sink   (input valid, read_real, read_imag, status, saturated, output ready);
endinterface

// File: sv/qubit_state_vector_gate_engine.sv
// Top level of the state vector gate engine: amplitude memory, sequencer, gate MAC.
// Depends on qsvge_pkg and the channel interfaces in qsvge_if.sv.
//
//  channel   dir   handshake     carries
//  req_ch    in    valid/ready   opcode, qubits, amp_index, load amplitude
//  rsp_ch    out   valid/ready   read amplitude, status, saturated
//  csr_*     in    write enable  gate matrix registers, 16 bit each
//
// One transaction at a time; the amplitude memory has one write port and one
// read port with a registered read. A gate reads, computes and writes back
// every pair; a cnot swaps only the pairs with the control bit set. After reset
// the engine sweeps every address to rebuild |0..0> and takes no request
// meanwhile. A waiting response does not block the next request; it stalls
// only the hand-off of the next result.
module qubit_state_vector_gate_engine #(
   parameter int QUBIT_COUNT = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   qsvge_req_if.sink                           req_ch,
   qsvge_rsp_if.source                         rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [qsvge_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qsvge_pkg::PART_W-1:0]        csr_data
);

   localparam int AW  = QUBIT_COUNT;
   localparam int DIM = 1 << QUBIT_COUNT;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DIM - 1);
   localparam logic [AW-1:0] LAST_PAIR = AW'(DIM / 2 - 1);
   localparam int PW  = qsvge_pkg::PART_W;
   localparam int SW  = 2 * PW + 3;

   // amplitude memory
   logic [qsvge_pkg::AMP_W-1:0] mem [DIM];
   logic [qsvge_pkg::AMP_W-1:0] rdata_ff;
   logic [AW-1:0]               raddr;
   logic [AW-1:0]               waddr;
   logic [qsvge_pkg::AMP_W-1:0] wdata;
   logic                        wen;

   qsvge_pkg::state_type state_ff, state_in;
   logic [AW-1:0]                  cnt_ff, cnt_in;
   logic                           clr_rsp_ff, clr_rsp_in;
   logic [qsvge_pkg::OPCODE_W-1:0] op_ff;
   logic [AW-1:0]                  tm_ff, cm_ff;
   logic [AW-1:0]                  idx_ff;
   logic [qsvge_pkg::AMP_W-1:0]    a_ff, b_ff;
   logic [2:0]                     phase_ff;
   logic signed [2*PW-1:0]         prod_ff [4];
   logic signed [PW-1:0]           part_ff [4];
   logic signed [PW-1:0]           gate_ff [qsvge_pkg::NUM_REGS];

   logic signed [PW-1:0]           res_re_ff, res_im_ff;
   logic [qsvge_pkg::STATUS_W-1:0] status_ff;
   logic                           sat_ff;

   logic                           rsp_valid_ff;
   logic signed [PW-1:0]           rsp_re_ff, rsp_im_ff;
   logic [qsvge_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                           rsp_sat_ff;

   logic accept;
   logic [AW-1:0] low, ia, ib;
   logic [AW-1:0] req_tm, req_cm;
   logic tq_bad, cq_bad;
   logic deliver;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == qsvge_pkg::ST_IDLE);

   assign tq_bad = {1'b0, req_ch.target_qubit} >= 5'(QUBIT_COUNT);
   assign cq_bad = {1'b0, req_ch.control_qubit} >= 5'(QUBIT_COUNT);
   assign req_tm = AW'(1) << req_ch.target_qubit;
   assign req_cm = AW'(1) << req_ch.control_qubit;

   // pair addresses: insert a zero at the target bit of the pair count
   assign low = tm_ff - AW'(1);
   assign ia  = ((cnt_ff & ~low) << 1) | (cnt_ff & low);
   assign ib  = ia | tm_ff;

   assign deliver = (state_ff == qsvge_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // ---------------- gate MAC: four products per part ----------------
   logic row, im_sel;
   logic signed [PW-1:0] mr, mi, nr, ni, x0, x1, x2, x3;
   logic signed [PW-1:0] ar, ai, br, bi;
   logic [1:0] k_prev;
   logic signed [SW-1:0] sum, biased;
   logic signed [SW-16:0] rnd;
   logic signed [PW-1:0] sat_val;
   logic clip;

   assign row    = phase_ff[1];
   assign im_sel = phase_ff[0];
   assign ar = a_ff[2*PW-1:PW];
   assign ai = a_ff[PW-1:0];
   assign br = b_ff[2*PW-1:PW];
   assign bi = b_ff[PW-1:0];
   assign mr = row ? gate_ff[qsvge_pkg::REG_M10_RE] : gate_ff[qsvge_pkg::REG_M00_RE];
   assign mi = row ? gate_ff[qsvge_pkg::REG_M10_IM] : gate_ff[qsvge_pkg::REG_M00_IM];
   assign nr = row ? gate_ff[qsvge_pkg::REG_M11_RE] : gate_ff[qsvge_pkg::REG_M01_RE];
   assign ni = row ? gate_ff[qsvge_pkg::REG_M11_IM] : gate_ff[qsvge_pkg::REG_M01_IM];
   assign x0 = im_sel ? ai : ar;
   assign x1 = im_sel ? ar : ai;
   assign x2 = im_sel ? bi : br;
   assign x3 = im_sel ? br : bi;

   // sum stage works on the part issued in the cycle before
   assign k_prev = 2'(phase_ff - 3'd1);
   always_comb begin
      if (k_prev[0]) begin
         sum = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]) + SW'(prod_ff[3]);
      end else begin
         sum = SW'(prod_ff[0]) - SW'(prod_ff[1]) + SW'(prod_ff[2]) - SW'(prod_ff[3]);
      end
      biased = sum + SW'(16384);
      rnd    = biased[SW-1:15];
      clip   = 1'b0;
      if (rnd > (SW-15)'(qsvge_pkg::MAX_Q15)) begin
         sat_val = qsvge_pkg::MAX_Q15;
         clip    = 1'b1;
      end else if (rnd < (SW-15)'(qsvge_pkg::MIN_Q15)) begin
         sat_val = qsvge_pkg::MIN_Q15;
         clip    = 1'b1;
      end else begin
         sat_val = rnd[PW-1:0];
      end
   end

   // ---------------- memory ports ----------------
   always_comb begin
      raddr = ia;
      wen   = 1'b0;
      waddr = ia;
      wdata = '0;
      priority case (1'b1)
         state_ff == qsvge_pkg::ST_RD: begin
            raddr = idx_ff;
         end
         state_ff == qsvge_pkg::ST_RDB: begin
            raddr = ib;
         end
         state_ff == qsvge_pkg::ST_CLEAR: begin
            wen   = 1'b1;
            waddr = cnt_ff;
            wdata = (cnt_ff == '0) ? {qsvge_pkg::ONE_Q15, PW'(0)} : '0;
         end
         accept && (req_ch.opcode == qsvge_pkg::OP_LOAD): begin
            wen   = 1'b1;
            waddr = AW'(req_ch.amp_index);
            wdata = {req_ch.load_real, req_ch.load_imag};
         end
         state_ff == qsvge_pkg::ST_WRA: begin
            wen   = 1'b1;
            waddr = ia;
            wdata = (op_ff == qsvge_pkg::OP_GATE) ? {part_ff[0], part_ff[1]} : b_ff;
         end
         state_ff == qsvge_pkg::ST_WRB: begin
            wen   = 1'b1;
            waddr = ib;
            wdata = (op_ff == qsvge_pkg::OP_GATE) ? {part_ff[2], part_ff[3]} : a_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      unique case (state_ff)
         qsvge_pkg::ST_CLEAR: begin
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = clr_rsp_ff ? qsvge_pkg::ST_DONE : qsvge_pkg::ST_IDLE;
            end
         end
         qsvge_pkg::ST_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               state_in = qsvge_pkg::ST_DONE;
               unique case (req_ch.opcode)
                  qsvge_pkg::OP_RESET: begin
                     state_in   = qsvge_pkg::ST_CLEAR;
                     clr_rsp_in = 1'b1;
                  end
                  qsvge_pkg::OP_READ: state_in = qsvge_pkg::ST_RD;
                  qsvge_pkg::OP_GATE: begin
                     if (!tq_bad) state_in = qsvge_pkg::ST_RDA;
                  end
                  qsvge_pkg::OP_CNOT: begin
                     if (!tq_bad && !cq_bad && req_ch.target_qubit != req_ch.control_qubit)
                        state_in = qsvge_pkg::ST_RDA;
                  end
                  default: state_in = qsvge_pkg::ST_DONE;
               endcase
            end
         end
         qsvge_pkg::ST_RD:   state_in = qsvge_pkg::ST_RDW;
         qsvge_pkg::ST_RDW:  state_in = qsvge_pkg::ST_DONE;
         qsvge_pkg::ST_RDA: begin
            // skip pairs whose control bit is clear
            if (op_ff == qsvge_pkg::OP_CNOT && (ia & cm_ff) == '0) begin
               if (cnt_ff == LAST_PAIR) begin
                  state_in = qsvge_pkg::ST_DONE;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end else begin
               state_in = qsvge_pkg::ST_RDB;
            end
         end
         qsvge_pkg::ST_RDB:  state_in = qsvge_pkg::ST_CAPB;
         qsvge_pkg::ST_CAPB: begin
            state_in = (op_ff == qsvge_pkg::OP_GATE) ? qsvge_pkg::ST_MAC : qsvge_pkg::ST_WRA;
         end
         qsvge_pkg::ST_MAC: begin
            if (phase_ff == 3'd4) state_in = qsvge_pkg::ST_WRA;
         end
         qsvge_pkg::ST_WRA:  state_in = qsvge_pkg::ST_WRB;
         qsvge_pkg::ST_WRB: begin
            if (cnt_ff == LAST_PAIR) begin
               state_in = qsvge_pkg::ST_DONE;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = qsvge_pkg::ST_RDA;
            end
         end
         qsvge_pkg::ST_DONE: begin
            if (deliver) begin
               state_in   = qsvge_pkg::ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         default: state_in = qsvge_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= qsvge_pkg::ST_CLEAR;
         cnt_ff     <= '0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   // ---------------- command, operands and result ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_ch.opcode;
         tm_ff     <= req_tm;
         cm_ff     <= req_cm;
         idx_ff    <= AW'(req_ch.amp_index);
         res_re_ff <= '0;
         res_im_ff <= '0;
         sat_ff    <= 1'b0;
         status_ff <= qsvge_pkg::STATUS_OK;
         if (req_ch.opcode == qsvge_pkg::OP_GATE && tq_bad) begin
            status_ff <= qsvge_pkg::STATUS_BAD_QUBIT;
         end else if (req_ch.opcode == qsvge_pkg::OP_CNOT) begin
            if (tq_bad || cq_bad) begin
               status_ff <= qsvge_pkg::STATUS_BAD_QUBIT;
            end else if (req_ch.target_qubit == req_ch.control_qubit) begin
               status_ff <= qsvge_pkg::STATUS_SAME_QUBIT;
            end
         end
      end
      if (state_ff == qsvge_pkg::ST_RDW) begin
         res_re_ff <= rdata_ff[2*PW-1:PW];
         res_im_ff <= rdata_ff[PW-1:0];
      end
      if (state_ff == qsvge_pkg::ST_RDB) begin
         a_ff <= rdata_ff;
      end
      if (state_ff == qsvge_pkg::ST_CAPB) begin
         b_ff     <= rdata_ff;
         phase_ff <= 3'd0;
      end
      if (state_ff == qsvge_pkg::ST_MAC) begin
         phase_ff   <= phase_ff + 3'd1;
         prod_ff[0] <= mr * x0;
         prod_ff[1] <= mi * x1;
         prod_ff[2] <= nr * x2;
         prod_ff[3] <= ni * x3;
         if (phase_ff != 3'd0) begin
            part_ff[k_prev] <= sat_val;
            if (clip) sat_ff <= 1'b1;
         end
      end
   end

   // ---------------- gate matrix registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < qsvge_pkg::NUM_REGS; r++) begin
            gate_ff[r] <= '0;
         end
         gate_ff[qsvge_pkg::REG_M00_RE] <= qsvge_pkg::ONE_Q15;
         gate_ff[qsvge_pkg::REG_M11_RE] <= qsvge_pkg::ONE_Q15;
      end else if (csr_write_enable && !csr_index[qsvge_pkg::CSR_IDX_W-1]) begin
         // indexes beyond the register list drop the write
         gate_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         rsp_re_ff     <= res_re_ff;
         rsp_im_ff     <= res_im_ff;
         rsp_status_ff <= status_ff;
         rsp_sat_ff    <= sat_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_real = rsp_re_ff;
   assign rsp_ch.read_imag = rsp_im_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

endmodule

// File: tb/sv/qsvge_scoreboard.sv
`timescale 1ns / 100ps
// Result checker for the state vector gate engine testbench.
// Depends on qsvge_pkg; holds the expected responses in arrival order.
package qsvge_scoreboard_pkg;

   typedef struct packed {
      logic signed [qsvge_pkg::PART_W-1:0] read_real;
      logic signed [qsvge_pkg::PART_W-1:0] read_imag;
      logic [qsvge_pkg::STATUS_W-1:0]      status;
      logic                                saturated;
   } response_type;

   class response_checker;
      response_type pending[$];
      int           mismatches;
      int           unexpected;
      int           matched;

      function new();
         mismatches = 0;
         unexpected = 0;
         matched    = 0;
      endfunction

      function void note_request(response_type r);
         pending.push_back(r);
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (pending.size() == 0) begin
            unexpected++;
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with none pending: re=%0d im=%0d st=%0d sat=%0d",
                        $time, got.read_real, got.read_imag, got.status, got.saturated);
            return;
         end
         want = pending.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: mismatch: want re=%0d im=%0d st=%0d sat=%0d, ",
                         "got re=%0d im=%0d st=%0d sat=%0d"},
                        $time, want.read_real, want.read_imag, want.status, want.saturated,
                        got.read_real, got.read_imag, got.status, got.saturated);
         end else begin
            matched++;
         end
      endfunction
   endclass
endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for qubit_state_vector_gate_engine.
// Depends on qsvge_pkg, qsvge_if.sv and qsvge_scoreboard.sv.
module tb_top;

   localparam int NQ  = 10;
   localparam int DIM = 1 << NQ;
   // slowest transaction is a gate, plus the reset sweep
   localparam int WATCHDOG_LIMIT = 40 * DIM + 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [qsvge_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [qsvge_pkg::PART_W-1:0]    csr_data  = '0;

   qsvge_req_if req_ch();
   qsvge_rsp_if rsp_ch();

   qubit_state_vector_gate_engine #(.QUBIT_COUNT(NQ)) u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: own copy of the gate matrix and the amplitude vector.
   logic signed [qsvge_pkg::PART_W-1:0] gate_m [qsvge_pkg::NUM_REGS];
   logic [qsvge_pkg::AMP_W-1:0]         amps   [DIM];

   qsvge_scoreboard_pkg::response_checker sb = new();

   int send_idle_pct = 0;   // sender gap chance, percent
   int recv_stall_pct = 0;  // receiver stall chance, percent
   int sent_count = 0;
   int gate_count = 0;
   int cnot_count = 0;
   int idle_cycles = 0;
   bit timed_out = 0;

   function automatic void clear_amps();
      for (int i = 0; i < DIM; i++) amps[i] = '0;
      amps[0] = {qsvge_pkg::ONE_Q15, 16'sd0};
   endfunction

   // Round a Q4.30 sum half up to Q1.15 and clip.
   function automatic logic signed [qsvge_pkg::PART_W-1:0] round_clip(longint sum,
                                                                       ref bit sat);
      longint r;
      r = (sum + 64'sd16384) >>> 15;
      if (r > 32767) begin sat = 1; return qsvge_pkg::MAX_Q15; end
      if (r < -32768) begin sat = 1; return qsvge_pkg::MIN_Q15; end
      return r[qsvge_pkg::PART_W-1:0];
   endfunction

   function automatic logic [qsvge_pkg::AMP_W-1:0] gate_mac(int ka, int kb,
                                                            logic [qsvge_pkg::AMP_W-1:0] a,
                                                            logic [qsvge_pkg::AMP_W-1:0] b,
                                                            ref bit sat);
      longint mr, mi, nr, ni, ar, ai, br, bi, re, im;
      logic signed [qsvge_pkg::PART_W-1:0] r, q;
      mr = gate_m[ka]; mi = gate_m[ka+1]; nr = gate_m[kb]; ni = gate_m[kb+1];
      ar = $signed(a[31:16]); ai = $signed(a[15:0]);
      br = $signed(b[31:16]); bi = $signed(b[15:0]);
      re = mr*ar - mi*ai + nr*br - ni*bi;
      im = mr*ai + mi*ar + nr*bi + ni*br;
      r = round_clip(re, sat);
      q = round_clip(im, sat);
      return {r, q};
   endfunction

   // Work out the response of one accepted request and update the vector.
   function automatic qsvge_scoreboard_pkg::response_type predict_response(
         logic [2:0] op, logic [3:0] tq, logic [3:0] cq, logic [9:0] idx_in,
         logic [15:0] lre, logic [15:0] lim);
      qsvge_scoreboard_pkg::response_type r;
      bit sat;
      int idx, tm, cm;
      logic [qsvge_pkg::AMP_W-1:0] a, b;
      r = '0;
      sat = 0;
      idx = idx_in & (DIM - 1);
      case (op)
         qsvge_pkg::OP_RESET: clear_amps();
         qsvge_pkg::OP_LOAD:  amps[idx] = {lre, lim};
         qsvge_pkg::OP_GATE: begin
            if (tq >= NQ) r.status = qsvge_pkg::STATUS_BAD_QUBIT;
            else begin
               tm = 1 << tq;
               for (int i = 0; i < DIM; i++) begin
                  if ((i & tm) == 0) begin
                     a = amps[i];
                     b = amps[i | tm];
                     amps[i] = gate_mac(0, 2, a, b, sat);
                     amps[i | tm] = gate_mac(4, 6, a, b, sat);
                  end
               end
            end
         end
         qsvge_pkg::OP_CNOT: begin
            if (tq >= NQ || cq >= NQ) r.status = qsvge_pkg::STATUS_BAD_QUBIT;
            else if (tq == cq) r.status = qsvge_pkg::STATUS_SAME_QUBIT;
            else begin
               tm = 1 << tq;
               cm = 1 << cq;
               for (int i = 0; i < DIM; i++) begin
                  if ((i & cm) != 0 && (i & tm) == 0) begin
                     a = amps[i];
                     amps[i] = amps[i | tm];
                     amps[i | tm] = a;
                  end
               end
            end
         end
         qsvge_pkg::OP_READ: begin
            r.read_real = amps[idx][31:16];
            r.read_imag = amps[idx][15:0];
         end
         default: ;
      endcase
      r.saturated = sat;
      return r;
   endfunction

   // Receiver: stall at random, check every accepted response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response({rsp_ch.read_real, rsp_ch.read_imag,
                               rsp_ch.status, rsp_ch.saturated});
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("watchdog expired after %0d quiet cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Write one gate register; the model copy follows at once.
   task automatic write_reg(logic [2:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= {1'b0, idx};
      csr_data <= value;
      gate_m[idx] = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Write an index past the register list; it must be ignored.
   task automatic write_unused_reg(logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= 4'd8 + 4'($urandom_range(7));
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_matrix(logic [15:0] m0, m1, m2, m3, m4, m5, m6, m7);
      write_reg(qsvge_pkg::REG_M00_RE, m0); write_reg(qsvge_pkg::REG_M00_IM, m1);
      write_reg(qsvge_pkg::REG_M01_RE, m2); write_reg(qsvge_pkg::REG_M01_IM, m3);
      write_reg(qsvge_pkg::REG_M10_RE, m4); write_reg(qsvge_pkg::REG_M10_IM, m5);
      write_reg(qsvge_pkg::REG_M11_RE, m6); write_reg(qsvge_pkg::REG_M11_IM, m7);
   endtask

   // Drive one transaction and hold it until accepted; optional gap before.
   task automatic send_request(logic [2:0] op, logic [3:0] tq, logic [3:0] cq,
                               logic [9:0] idx, logic [15:0] lre, logic [15:0] lim);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.target_qubit <= tq;
      req_ch.control_qubit <= cq;
      req_ch.amp_index <= idx;
      req_ch.load_real <= lre;
      req_ch.load_imag <= lim;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(predict_response(op, tq, cq, idx, lre, lim));
      sent_count++;
      if (op == qsvge_pkg::OP_GATE) gate_count++;
      if (op == qsvge_pkg::OP_CNOT) cnot_count++;
   endtask

   // Drop valid and wait until every pending response is back, then settle.
   task automatic drain();
      @(posedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random mix: loads, gates, cnots, reads, resets and unused opcodes, some bad qubits.
   task automatic random_request();
      int pick;
      logic [3:0] tq, cq;
      pick = $urandom_range(99);
      tq = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(NQ - 1));
      cq = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(NQ - 1));
      if (pick < 35)
         send_request(qsvge_pkg::OP_LOAD, 4'($urandom), 4'($urandom), 10'($urandom),
                      16'($urandom), 16'($urandom));
      else if (pick < 50)
         send_request(qsvge_pkg::OP_GATE, tq, cq, 10'($urandom), 16'($urandom),
                      16'($urandom));
      else if (pick < 62)
         send_request(qsvge_pkg::OP_CNOT, tq, cq, 10'($urandom), 16'($urandom),
                      16'($urandom));
      else if (pick < 94)
         send_request(qsvge_pkg::OP_READ, 4'($urandom), 4'($urandom), 10'($urandom),
                      16'($urandom), 16'($urandom));
      else if (pick < 96)
         send_request(qsvge_pkg::OP_RESET, tq, cq, 10'($urandom), 16'($urandom),
                      16'($urandom));
      else
         send_request(3'(5 + $urandom_range(2)), 4'($urandom), 4'($urandom), 10'($urandom),
                      16'($urandom), 16'($urandom));
   endtask

   initial begin
      logic [15:0] hq;
      req_ch.valid = 1'b0;
      req_ch.opcode = '0;
      req_ch.target_qubit = '0;
      req_ch.control_qubit = '0;
      req_ch.amp_index = '0;
      req_ch.load_real = '0;
      req_ch.load_imag = '0;
      // model reset state
      for (int i = 0; i < qsvge_pkg::NUM_REGS; i++) gate_m[i] = '0;
      gate_m[qsvge_pkg::REG_M00_RE] = qsvge_pkg::ONE_Q15;
      gate_m[qsvge_pkg::REG_M11_RE] = qsvge_pkg::ONE_Q15;
      clear_amps();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: identity gate at reset values, field extremes, every defined opcode.
      send_request(qsvge_pkg::OP_READ, 4'd0, 4'd0, 10'd0, 16'h0000, 16'h0000);
      send_request(qsvge_pkg::OP_GATE, 4'd0, 4'd0, 10'd0, 16'h0000, 16'h0000);
      send_request(qsvge_pkg::OP_LOAD, 4'hF, 4'hF, 10'h3FF, 16'h7FFF, 16'h8000);
      send_request(qsvge_pkg::OP_LOAD, 4'd0, 4'd0, 10'd1, 16'h8000, 16'h7FFF);
      send_request(qsvge_pkg::OP_READ, 4'd0, 4'd0, 10'h3FF, 16'hFFFF, 16'hFFFF);
      send_request(qsvge_pkg::OP_GATE, 4'd9, 4'd0, 10'd0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_GATE, 4'd10, 4'd0, 10'd0, 16'h0, 16'h0);  // bad target
      send_request(qsvge_pkg::OP_GATE, 4'hF, 4'd0, 10'd0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_CNOT, 4'd0, 4'd9, 10'd0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_CNOT, 4'd3, 4'd3, 10'd0, 16'h0, 16'h0);   // same qubit
      send_request(qsvge_pkg::OP_CNOT, 4'd12, 4'd3, 10'd0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_CNOT, 4'd2, 4'd15, 10'd0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_READ, 4'd0, 4'd0, 10'h1FE, 16'h0, 16'h0);
      send_request(3'd5, 4'hF, 4'hF, 10'h3FF, 16'hFFFF, 16'hFFFF);
      send_request(3'd7, 4'h0, 4'h0, 10'h0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_RESET, 4'd0, 4'd0, 10'd0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_READ, 4'd0, 4'd0, 10'd0, 16'h0, 16'h0);
      drain();

      // Extreme matrix: every entry most negative, forces clipping.
      load_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 16'h8000, 16'h8000);
      write_unused_reg(16'h1234);
      send_request(qsvge_pkg::OP_LOAD, 4'd0, 4'd0, 10'd1, 16'h8000, 16'h8000);
      send_request(qsvge_pkg::OP_GATE, 4'd0, 4'd0, 10'd0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_READ, 4'd0, 4'd0, 10'd0, 16'h0, 16'h0);
      send_request(qsvge_pkg::OP_READ, 4'd0, 4'd0, 10'd1, 16'h0, 16'h0);
      drain();

      // Random phases, each with its own matrix and idling pattern.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         hq = 16'd23170;   // about 1/sqrt(2): Hadamard-like
         case (phase)
            0: load_matrix(hq, 16'h0000, hq, 16'h0000, hq, 16'h0000, -hq, 16'h0000);
            1: load_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
            2: load_matrix(16'h0000, 16'h0000, 16'h7FFF, 16'h0000,
                           16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
            default: begin
               for (int k = 0; k < qsvge_pkg::NUM_REGS; k++)
                  write_reg(3'(k), 16'($urandom));
            end
         endcase
         for (int n = 0; n < 70; n++) begin
            random_request();
            // hold off once per phase until the engine is quiet
            if (n == 35) drain();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d transactions (%0d gates, %0d cnots) over 6 matrix settings",
               sent_count, gate_count, cnot_count);
      $display("responses matched %0d, mismatches %0d, still pending %0d",
               sb.matched, sb.mismatches, sb.pending.size());
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// File: sim.f
sv/qsvge_pkg.sv
sv/qsvge_if.sv
sv/qubit_state_vector_gate_engine.sv
tb/sv/qsvge_scoreboard.sv
tb/sv/tb_top.sv
